// ===== rtl/point_in_tapered_cylinder_macros.svh =====
// ----------------------------------------------------------------------------
// Point in tapered cylinder: assertion macros
// Short forms for the concurrent checks of the top level. They use the
// module's clk and rst.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_TAPERED_CYLINDER_MACROS_SVH
`define POINT_IN_TAPERED_CYLINDER_MACROS_SVH

// same-cycle implication
`define PITC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pitc check failed");

// next-cycle implication
`define PITC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pitc check failed");

`endif

// ===== rtl/pitc_pkg.sv =====
// ----------------------------------------------------------------------------
// pitc_pkg
// Widths, register codes and shared helpers of the tapered cylinder test.
// ----------------------------------------------------------------------------
package pitc_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int AXIS_FRAC_BITS  = 14;
  // half heights at or below this count as a flat cylinder (this rounds to 0)
  localparam int FLAT_MAX        = (1 << COORD_FRAC_BITS) / 100000;

  localparam int LIMB_W      = 32;
  localparam int COORD_W     = 32;
  localparam int AXIS_COMP_W = 16;
  localparam int AXIS_W      = 3 * AXIS_COMP_W;
  localparam int HALF_W      = 31;
  localparam int TOP_W       = 31;
  localparam int BOT_W       = 32;
  localparam int RADII_W     = TOP_W + BOT_W;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 64;

  // local coordinates
  localparam int D_W    = COORD_W + 1;
  localparam int PROD_W = D_W + AXIS_COMP_W;
  localparam int LOC_W  = PROD_W + 1;
  localparam int MAG_W  = LOC_W - 1;
  localparam int HS_W   = HALF_W + AXIS_FRAC_BITS;
  localparam int Y_W    = HS_W + 1;
  localparam int YL_W   = Y_W / 2;
  localparam int YH_W   = Y_W - YL_W;

  // squares of x and z
  localparam int SQ_HI_W = MAG_W - LIMB_W;
  localparam int PP_LL_W = 2 * LIMB_W;
  localparam int PP_LH_W = LIMB_W + SQ_HI_W;
  localparam int PP_HH_W = 2 * SQ_HI_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int LHS_W   = SQ_W + 1;

  // radius numerator
  localparam int BT_W   = BOT_W + 1;
  localparam int DF_W   = BOT_W + 1;
  localparam int HB_W   = HALF_W + BT_W;
  localparam int YLDF_W = YL_W + 1 + DF_W;
  localparam int YHDF_W = YH_W + DF_W;
  localparam int NUM_W  = BOT_W + HS_W + 1;
  localparam int NUMF_W = NUM_W + 2;

  // scaled compare
  localparam int H_W    = HALF_W + 1;
  localparam int H2_W   = 2 * H_W;
  localparam int L3_W   = LHS_W - 3 * LIMB_W;
  localparam int PP_W   = 2 * LIMB_W;
  localparam int PP3_W  = L3_W + LIMB_W;
  localparam int U_W    = 3 * LIMB_W + 2;
  localparam int V_W    = 3 * LIMB_W + 2;
  localparam int L_W    = LHS_W + H2_W;
  localparam int N2H_W  = NUM_W - 2 * LIMB_W;
  localparam int NN02_W = LIMB_W + N2H_W;
  localparam int NN22_W = 2 * N2H_W;
  localparam int SA_W   = 3 * LIMB_W + 2;
  localparam int SB_W   = 2 * LIMB_W + N2H_W + 3;
  localparam int N2_W   = 2 * NUM_W;

  localparam int NUM_STAGES = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_AXIS  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UP_AXIS     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_AXIS   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RADII       = 4'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [AXIS_W-1:0]         right_axis;
    logic [AXIS_W-1:0]         up_axis;
    logic [AXIS_W-1:0]         view_axis;
    logic [HALF_W-1:0]         half_height;
    logic [RADII_W-1:0]        radii;
  } cfg_t;

  function automatic logic is_flat(input logic [HALF_W-1:0] half);
    return half <= HALF_W'(FLAT_MAX);
  endfunction

endpackage

// ===== rtl/pitc_local.sv =====
// ----------------------------------------------------------------------------
// pitc_local
// Stages 1-4: center subtract, axis projection, local y range test and
// magnitudes of local x and z.
// ----------------------------------------------------------------------------
module pitc_local (
  input  logic                              clk,
  input  logic [3:0]                        adv,
  input  pitc_pkg::cfg_t                    cfg,
  input  logic signed [pitc_pkg::COORD_W-1:0] point_x,
  input  logic signed [pitc_pkg::COORD_W-1:0] point_y,
  input  logic signed [pitc_pkg::COORD_W-1:0] point_z,
  output logic [pitc_pkg::MAG_W-1:0]        mag_x,
  output logic [pitc_pkg::MAG_W-1:0]        mag_z,
  output logic signed [pitc_pkg::Y_W-1:0]   loc_y,
  output logic                              y_ok
);
  import pitc_pkg::*;

  function automatic logic signed [AXIS_COMP_W-1:0] axis_comp(
    input logic [AXIS_W-1:0] axis,
    input int                k
  );
    return axis[AXIS_COMP_W*k +: AXIS_COMP_W];
  endfunction

  logic [AXIS_W-1:0]        ax   [3];
  logic signed [D_W-1:0]    d    [3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [LOC_W-1:0]  loc  [3];
  logic signed [LOC_W-1:0]  hs;

  assign ax[0] = cfg.right_axis;
  assign ax[1] = cfg.up_axis;
  assign ax[2] = cfg.view_axis;
  assign hs    = LOC_W'($signed({1'b0, cfg.half_height, {AXIS_FRAC_BITS{1'b0}}}));

  // stage 1: offset from center
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d[0] <= D_W'(point_x) - D_W'(cfg.center_x);
      d[1] <= D_W'(point_y) - D_W'(cfg.center_y);
      d[2] <= D_W'(point_z) - D_W'(cfg.center_z);
    end
  end

  // stage 2: nine component products
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          prod[a][k] <= PROD_W'(axis_comp(ax[a], k)) * PROD_W'(d[k]);
        end
      end
    end
  end

  // stage 3: dot products
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int a = 0; a < 3; a++) begin
        loc[a] <= LOC_W'(prod[a][0]) + LOC_W'(prod[a][1]) + LOC_W'(prod[a][2]);
      end
    end
  end

  // stage 4: height test, magnitudes
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      y_ok  <= (loc[1] >= -hs) && (loc[1] <= hs);
      mag_x <= loc[0][LOC_W-1] ? MAG_W'(-loc[0]) : MAG_W'(loc[0]);
      mag_z <= loc[2][LOC_W-1] ? MAG_W'(-loc[2]) : MAG_W'(loc[2]);
      loc_y <= loc[1][Y_W-1:0];
    end
  end

endmodule

// ===== rtl/pitc_square.sv =====
// ----------------------------------------------------------------------------
// pitc_square
// Stages 5-7: x^2 + z^2 and the radius numerator
// bot*(hs-y) + top*(hs+y), or top scaled for a flat cylinder.
// ----------------------------------------------------------------------------
module pitc_square (
  input  logic                            clk,
  input  logic [2:0]                      adv,
  input  pitc_pkg::cfg_t                  cfg,
  input  logic [pitc_pkg::MAG_W-1:0]      mag_x,
  input  logic [pitc_pkg::MAG_W-1:0]      mag_z,
  input  logic signed [pitc_pkg::Y_W-1:0] loc_y,
  input  logic                            y_ok,
  output logic [pitc_pkg::LHS_W-1:0]      lhs,
  output logic [pitc_pkg::NUM_W-1:0]      num,
  output logic                            sq_ok
);
  import pitc_pkg::*;

  logic [TOP_W-1:0]   top;
  logic [BOT_W-1:0]   bot;
  logic [BT_W-1:0]    bt;
  logic signed [DF_W-1:0] df;
  logic [LIMB_W-1:0]  xl, zl;
  logic [SQ_HI_W-1:0] xh, zh;
  logic [YL_W-1:0]    yl;
  logic signed [YH_W-1:0] yh;

  assign top      = cfg.radii[RADII_W-1:BOT_W];
  assign bot      = cfg.radii[BOT_W-1:0];
  assign bt       = BT_W'(top) + BT_W'(bot);
  assign df       = $signed({2'b00, top}) - $signed({1'b0, bot});
  assign {xh, xl} = mag_x;
  assign {zh, zl} = mag_z;
  assign yl       = loc_y[YL_W-1:0];
  assign yh       = loc_y[Y_W-1:YL_W];

  // stage 5 registers
  logic [PP_LL_W-1:0] x_ll, z_ll;
  logic [PP_LH_W-1:0] x_lh, z_lh;
  logic [PP_HH_W-1:0] x_hh, z_hh;
  logic [HB_W-1:0]    hb;
  logic signed [YLDF_W-1:0] yl_df;
  logic signed [YHDF_W-1:0] yh_df;
  logic               ok5;
  // stage 6 registers
  logic [SQ_W-1:0]    x2, z2;
  logic [NUM_W-1:0]   num6;
  logic               ok6;

  logic [NUMF_W-1:0]  num_full;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_ll  <= PP_LL_W'(xl) * PP_LL_W'(xl);
      x_lh  <= PP_LH_W'(xl) * PP_LH_W'(xh);
      x_hh  <= PP_HH_W'(xh) * PP_HH_W'(xh);
      z_ll  <= PP_LL_W'(zl) * PP_LL_W'(zl);
      z_lh  <= PP_LH_W'(zl) * PP_LH_W'(zh);
      z_hh  <= PP_HH_W'(zh) * PP_HH_W'(zh);
      hb    <= HB_W'(cfg.half_height) * HB_W'(bt);
      yl_df <= YLDF_W'($signed({1'b0, yl})) * YLDF_W'(df);
      yh_df <= YHDF_W'(yh) * YHDF_W'(df);
      ok5   <= y_ok;
    end
  end

  // hs*(bot+top) + y*(top-bot), with y split in two halves
  assign num_full = (NUMF_W'(hb) << AXIS_FRAC_BITS) + (NUMF_W'(yh_df) << YL_W)
                  + NUMF_W'(yl_df);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      x2   <= (SQ_W'(x_hh) << (2 * LIMB_W)) + (SQ_W'(x_lh) << (LIMB_W + 1)) + SQ_W'(x_ll);
      z2   <= (SQ_W'(z_hh) << (2 * LIMB_W)) + (SQ_W'(z_lh) << (LIMB_W + 1)) + SQ_W'(z_ll);
      num6 <= is_flat(cfg.half_height) ? NUM_W'({top, {AXIS_FRAC_BITS{1'b0}}})
                                       : num_full[NUM_W-1:0];
      ok6  <= ok5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      lhs   <= LHS_W'(x2) + LHS_W'(z2);
      num   <= num6;
      sq_ok <= ok6;
    end
  end

endmodule

// ===== rtl/pitc_scale_cmp.sv =====
// ----------------------------------------------------------------------------
// pitc_scale_cmp
// Stages 8-11: lhs * H^2 against num^2 from 32-bit partial products, then
// the final inclusive compare.
// ----------------------------------------------------------------------------
module pitc_scale_cmp (
  input  logic                       clk,
  input  logic [3:0]                 adv,
  input  logic [pitc_pkg::H2_W-1:0]  h2,
  input  logic [pitc_pkg::LHS_W-1:0] lhs,
  input  logic [pitc_pkg::NUM_W-1:0] num,
  input  logic                       sq_ok,
  output logic                       hit
);
  import pitc_pkg::*;

  logic [LIMB_W-1:0] l0, l1, l2, g0, g1, n0, n1;
  logic [L3_W-1:0]   l3;
  logic [N2H_W-1:0]  n2;

  assign l0 = lhs[LIMB_W-1:0];
  assign l1 = lhs[2*LIMB_W-1:LIMB_W];
  assign l2 = lhs[3*LIMB_W-1:2*LIMB_W];
  assign l3 = lhs[LHS_W-1:3*LIMB_W];
  assign g0 = h2[LIMB_W-1:0];
  assign g1 = h2[H2_W-1:LIMB_W];
  assign n0 = num[LIMB_W-1:0];
  assign n1 = num[2*LIMB_W-1:LIMB_W];
  assign n2 = num[NUM_W-1:2*LIMB_W];

  // stage 8: partial products
  logic [PP_W-1:0]   pp00, pp01, pp10, pp11, pp20, pp21;
  logic [PP3_W-1:0]  pp30, pp31;
  logic [PP_W-1:0]   nn00, nn01, nn11;
  logic [NN02_W-1:0] nn02, nn12;
  logic [NN22_W-1:0] nn22;
  logic              ok8;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pp00 <= PP_W'(l0) * PP_W'(g0);
      pp01 <= PP_W'(l0) * PP_W'(g1);
      pp10 <= PP_W'(l1) * PP_W'(g0);
      pp11 <= PP_W'(l1) * PP_W'(g1);
      pp20 <= PP_W'(l2) * PP_W'(g0);
      pp21 <= PP_W'(l2) * PP_W'(g1);
      pp30 <= PP3_W'(l3) * PP3_W'(g0);
      pp31 <= PP3_W'(l3) * PP3_W'(g1);
      nn00 <= PP_W'(n0) * PP_W'(n0);
      nn01 <= PP_W'(n0) * PP_W'(n1);
      nn11 <= PP_W'(n1) * PP_W'(n1);
      nn02 <= NN02_W'(n0) * NN02_W'(n2);
      nn12 <= NN02_W'(n1) * NN02_W'(n2);
      nn22 <= NN22_W'(n2) * NN22_W'(n2);
      ok8  <= sq_ok;
    end
  end

  // stage 9: column groups
  logic [U_W-1:0]    u;
  logic [V_W-1:0]    v;
  logic [PP3_W-1:0]  w;
  logic [SA_W-1:0]   sa;
  logic [SB_W-1:0]   sb;
  logic [NN22_W-1:0] sc;
  logic              ok9;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      u   <= U_W'(pp00) + (U_W'(pp01) << LIMB_W) + (U_W'(pp10) << LIMB_W);
      v   <= V_W'(pp11) + V_W'(pp20) + (V_W'(pp21) << LIMB_W) + (V_W'(pp30) << LIMB_W);
      w   <= pp31;
      // cross terms of the square appear twice
      sa  <= SA_W'(nn00) + (SA_W'(nn01) << (LIMB_W + 1));
      sb  <= SB_W'(nn11) + (SB_W'(nn02) << 1) + (SB_W'(nn12) << (LIMB_W + 1));
      sc  <= nn22;
      ok9 <= ok8;
    end
  end

  // stage 10: full products
  logic [L_W-1:0]  l_sum;
  logic [N2_W-1:0] n_sq;
  logic            ok10;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      l_sum <= L_W'(u) + (L_W'(v) << (2 * LIMB_W)) + (L_W'(w) << (4 * LIMB_W));
      n_sq  <= N2_W'(sa) + (N2_W'(sb) << (2 * LIMB_W)) + (N2_W'(sc) << (4 * LIMB_W));
      ok10  <= ok9;
    end
  end

  // stage 11: result register
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      hit <= ok10 && (l_sum <= L_W'(n_sq));
    end
  end

endmodule

// ===== rtl/point_in_tapered_cylinder.sv =====
// ----------------------------------------------------------------------------
// point_in_tapered_cylinder
// Tests one Q15.16 world point per transaction against an oriented, tapered
// cylinder and returns 1 when the point lies inside or on the surface. The
// block is an 11-stage pipeline that takes a new point every cycle while the
// output keeps up. The stage count is set by the chain of wide multiplies
// (projection, squares, and the 163-bit scaled compare built from 32x32
// partial products), one register level per step. A stage holds its item
// only while it and all stages after it are full and the output stalls, so
// a stalled output only blocks input once all stages are occupied; in_ready
// drops then and nothing is lost or repeated. The test is exact: x^2+z^2 is
// scaled by (2*half)^2, or 1 for a flat cylinder, and checked against the
// squared radius numerator, with no rounding. Configuration writes
// (cfg_ready is always high) must be made while the pipeline is empty; a
// write takes effect for points accepted from the next cycle on. Indexes
// beyond the register list are ignored. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "point_in_tapered_cylinder_macros.svh"

module point_in_tapered_cylinder (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pitc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pitc_pkg::CFG_DATA_W-1:0]      cfg_data,
  // point channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pitc_pkg::COORD_W-1:0]  point_x,
  input  logic signed [pitc_pkg::COORD_W-1:0]  point_y,
  input  logic signed [pitc_pkg::COORD_W-1:0]  point_z,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 inside_res
);
  import pitc_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x    <= '0;
      cfg.center_y    <= '0;
      cfg.center_z    <= '0;
      cfg.right_axis  <= 48'd16384;
      cfg.up_axis     <= 48'd1073741824;
      cfg.view_axis   <= 48'd70368744177664;
      cfg.half_height <= 31'd32768;
      cfg.radii       <= 63'd140739635871744;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CENTER_X:    cfg.center_x    <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:    cfg.center_y    <= cfg_data[COORD_W-1:0];
        REG_CENTER_Z:    cfg.center_z    <= cfg_data[COORD_W-1:0];
        REG_RIGHT_AXIS:  cfg.right_axis  <= cfg_data[AXIS_W-1:0];
        REG_UP_AXIS:     cfg.up_axis     <= cfg_data[AXIS_W-1:0];
        REG_VIEW_AXIS:   cfg.view_axis   <= cfg_data[AXIS_W-1:0];
        REG_HALF_HEIGHT: cfg.half_height <= cfg_data[HALF_W-1:0];
        REG_RADII:       cfg.radii       <= cfg_data[RADII_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // Scale factor for the compare: (2*half)^2, or 1 for a flat cylinder.
  // Recomputed every cycle; an item reaches its use many cycles after a write.
  logic [H_W-1:0]  height2;
  logic [H2_W-1:0] h2;

  assign height2 = {cfg.half_height, 1'b0};

  always_ff @(posedge clk) begin
    h2 <= is_flat(cfg.half_height) ? H2_W'(1) : H2_W'(height2) * H2_W'(height2);
  end

  // --------------------------------------------------------------------------
  // Stage valids and advance enables
  // A stage may load when it is empty or everything below it can move.
  // --------------------------------------------------------------------------
  logic [NUM_STAGES:1]   v;
  logic [NUM_STAGES:1]   v_prev;
  logic [NUM_STAGES:1]   adv;
  logic                  in_acc;
  logic                  out_acc;

  for (genvar i = 1; i <= NUM_STAGES; i++) begin : g_adv
    assign adv[i] = out_ready || !(&v[NUM_STAGES:i]);
  end

  assign v_prev    = {v[NUM_STAGES-1:1], in_valid};
  assign in_ready  = adv[1];
  assign out_valid = v[NUM_STAGES];
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 1; i <= NUM_STAGES; i++) begin
        if (adv[i]) begin
          v[i] <= v_prev[i];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]      mag_x, mag_z;
  logic signed [Y_W-1:0] loc_y;
  logic                  y_ok;
  logic [LHS_W-1:0]      lhs;
  logic [NUM_W-1:0]      num;
  logic                  sq_ok;

  // stages 1-4: local coordinates and height test
  pitc_local u_local (
    .clk     (clk),
    .adv     (adv[4:1]),
    .cfg     (cfg),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z),
    .mag_x   (mag_x),
    .mag_z   (mag_z),
    .loc_y   (loc_y),
    .y_ok    (y_ok)
  );

  // stages 5-7: squared distance and radius numerator
  pitc_square u_square (
    .clk   (clk),
    .adv   (adv[7:5]),
    .cfg   (cfg),
    .mag_x (mag_x),
    .mag_z (mag_z),
    .loc_y (loc_y),
    .y_ok  (y_ok),
    .lhs   (lhs),
    .num   (num),
    .sq_ok (sq_ok)
  );

  // stages 8-11: scaled compare, last stage is the output register
  pitc_scale_cmp u_scale_cmp (
    .clk    (clk),
    .adv    (adv[11:8]),
    .h2     (h2),
    .lhs    (lhs),
    .num    (num),
    .sq_ok  (sq_ok),
    .hit    (inside_res)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // input must be open whenever a bubble exists or the output drains
  `PITC_ASSERT_IMP(a_ready_open, (!(&v) || out_ready), in_ready)
  // an accepted transaction lands in stage 1
  `PITC_ASSERT_NXT(a_enter, in_acc, v[1])
  // occupancy moves only with accepted transactions
  `PITC_ASSERT_NXT(a_occupancy, 1'b1, $countones(v) == $past($countones(v)) + $past(int'(in_acc)) - $past(int'(out_acc)))

endmodule
